// ===== sv/spin_yield_park_backoff_defines.svh =====
// ----------------------------------------------------------------------------
// Backoff controller assertion macros
// Shared concurrent check forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPIN_YIELD_PARK_BACKOFF_DEFINES_SVH
`define SPIN_YIELD_PARK_BACKOFF_DEFINES_SVH

// same-cycle implication
`define SYPB_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sypb: same-cycle check failed");

// next-cycle implication
`define SYPB_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sypb: next-cycle check failed");

`endif

// ===== sv/sypb_pkg.sv =====
// ----------------------------------------------------------------------------
// Backoff controller package
// Default widths, register indexes, reset values and action codes.
// ----------------------------------------------------------------------------
package sypb_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int PARK_WIDTH_DEFAULT  = 40;
   localparam int CSR_INDEX_WIDTH     = 8;
   localparam int ACTION_WIDTH        = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPIN_LIMIT  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_YIELD_LIMIT = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PARK_MIN    = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PARK_MAX    = 8'd3;

   // reset values, truncated to the configured width where used
   localparam logic [63:0] SPIN_LIMIT_RESET  = 64'd10;
   localparam logic [63:0] YIELD_LIMIT_RESET = 64'd5;
   localparam logic [63:0] PARK_MIN_RESET    = 64'd1000;
   localparam logic [63:0] PARK_MAX_RESET    = 64'd1000000;

   // result actions
   localparam logic [ACTION_WIDTH-1:0] ACT_NONE  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_SPIN  = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_YIELD = 2'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_PARK  = 2'd3;

endpackage

// ===== sv/sypb_if.sv =====
// ----------------------------------------------------------------------------
// Backoff controller channels
// Valid/ready channels for events, results and register writes.
// ----------------------------------------------------------------------------
interface sypb_req_if;
   logic valid;
   logic ready;
   logic had_work;

   modport source (output valid, output had_work, input ready);
   modport sink   (input valid, input had_work, output ready);
endinterface

interface sypb_rsp_if #(
   parameter int PARK_WIDTH = sypb_pkg::PARK_WIDTH_DEFAULT
);
   logic                                  valid;
   logic                                  ready;
   logic [sypb_pkg::ACTION_WIDTH-1:0]     action;
   logic [PARK_WIDTH-1:0]                 park_ns;

   modport source (output valid, output action, output park_ns, input ready);
   modport sink   (input valid, input action, input park_ns, output ready);
endinterface

interface sypb_csr_if #(
   parameter int DATA_WIDTH = sypb_pkg::PARK_WIDTH_DEFAULT
);
   logic                                  valid;
   logic                                  ready;
   logic [sypb_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [DATA_WIDTH-1:0]                 data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/spin_yield_park_backoff.sv =====
// ----------------------------------------------------------------------------
// Spin / yield / park backoff controller
// Exponential backoff for an idle polling loop, one event word per round.
// ----------------------------------------------------------------------------
// Takes one event word per polling round (had_work) and returns exactly one
// result word (action, park_ns) for it. Throughput is one word per clock: the
// whole update is a handful of compares, one increment per counter and a
// one-bit shift of the park period, done between the state registers and a
// single result register. req_if.ready is high while the result register
// is empty or being drained in the same cycle, so a full result register
// only holds off input when the consumer stalls. Register writes take effect
// on the next event; they never touch the phase, the counters or the current
// park period, and are always accepted. The csr data word must be at least
// max(COUNT_WIDTH, PARK_WIDTH) bits wide.
// ----------------------------------------------------------------------------
`include "spin_yield_park_backoff_defines.svh"

module spin_yield_park_backoff #(
   parameter int COUNT_WIDTH = sypb_pkg::COUNT_WIDTH_DEFAULT,
   parameter int PARK_WIDTH  = sypb_pkg::PARK_WIDTH_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   sypb_req_if.sink      req_if,
   sypb_rsp_if.source    rsp_if,
   sypb_csr_if.sink      csr_if
);

   // counters carry one extra bit so they can pass a limit at its maximum
   localparam int CNT_WIDTH = COUNT_WIDTH + 1;

   // phase codes
   localparam logic [1:0] PH_NOT_IDLE = 2'd0;
   localparam logic [1:0] PH_SPIN     = 2'd1;
   localparam logic [1:0] PH_YIELD    = 2'd2;
   localparam logic [1:0] PH_PARK     = 2'd3;

   // configuration
   logic [COUNT_WIDTH-1:0] spin_limit_ff, yield_limit_ff;
   logic [PARK_WIDTH-1:0]  park_min_ff, park_max_ff;

   // backoff state
   logic [1:0]             phase_ff, phase_in;
   logic [CNT_WIDTH-1:0]   spin_count_ff, spin_count_in;
   logic [CNT_WIDTH-1:0]   yield_count_ff, yield_count_in;
   logic [PARK_WIDTH-1:0]  park_period_ff, park_period_in;

   // result register
   logic                               rsp_valid_ff;
   logic [sypb_pkg::ACTION_WIDTH-1:0]  rsp_action_ff, rsp_action_in;
   logic [PARK_WIDTH-1:0]              rsp_park_ff, rsp_park_in;

   logic                   req_take;
   logic [CNT_WIDTH-1:0]   spin_bump, yield_bump;
   logic [PARK_WIDTH:0]    park_twice;

   assign req_if.ready   = !rsp_valid_ff || rsp_if.ready;
   assign req_take       = req_if.valid && req_if.ready;
   assign csr_if.ready   = 1'b1;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.action  = rsp_action_ff;
   assign rsp_if.park_ns = rsp_park_ff;

   // saturating increments; doubling kept at full precision
   assign spin_bump  = (spin_count_ff == '1) ? spin_count_ff :
                       spin_count_ff + CNT_WIDTH'(1);
   assign yield_bump = (yield_count_ff == '1) ? yield_count_ff :
                       yield_count_ff + CNT_WIDTH'(1);
   assign park_twice = {park_period_ff, 1'b0};

   always_comb begin
      phase_in       = phase_ff;
      spin_count_in  = spin_count_ff;
      yield_count_in = yield_count_ff;
      park_period_in = park_period_ff;
      rsp_action_in  = sypb_pkg::ACT_NONE;
      rsp_park_in    = '0;
      if (req_if.had_work) begin
         // work done: back to not idle, silent
         phase_in       = PH_NOT_IDLE;
         spin_count_in  = '0;
         yield_count_in = '0;
         park_period_in = park_min_ff;
      end else begin
         unique case (phase_ff)
            PH_NOT_IDLE: begin
               phase_in      = PH_SPIN;
               spin_count_in = spin_bump;
            end
            PH_SPIN: begin
               rsp_action_in = sypb_pkg::ACT_SPIN;
               spin_count_in = spin_bump;
               if (spin_bump > {1'b0, spin_limit_ff}) begin
                  phase_in       = PH_YIELD;
                  yield_count_in = '0;
               end
            end
            PH_YIELD: begin
               yield_count_in = yield_bump;
               // the round that passes the limit is silent
               if (yield_bump > {1'b0, yield_limit_ff}) begin
                  phase_in       = PH_PARK;
                  park_period_in = park_min_ff;
               end else begin
                  rsp_action_in = sypb_pkg::ACT_YIELD;
               end
            end
            default: begin
               rsp_action_in  = sypb_pkg::ACT_PARK;
               rsp_park_in    = park_period_ff;
               park_period_in = (park_twice < {1'b0, park_max_ff}) ?
                                park_twice[PARK_WIDTH-1:0] : park_max_ff;
            end
         endcase
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         spin_limit_ff  <= COUNT_WIDTH'(sypb_pkg::SPIN_LIMIT_RESET);
         yield_limit_ff <= COUNT_WIDTH'(sypb_pkg::YIELD_LIMIT_RESET);
         park_min_ff    <= PARK_WIDTH'(sypb_pkg::PARK_MIN_RESET);
         park_max_ff    <= PARK_WIDTH'(sypb_pkg::PARK_MAX_RESET);
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            sypb_pkg::REG_SPIN_LIMIT:  spin_limit_ff  <= csr_if.data[COUNT_WIDTH-1:0];
            sypb_pkg::REG_YIELD_LIMIT: yield_limit_ff <= csr_if.data[COUNT_WIDTH-1:0];
            sypb_pkg::REG_PARK_MIN:    park_min_ff    <= csr_if.data[PARK_WIDTH-1:0];
            sypb_pkg::REG_PARK_MAX:    park_max_ff    <= csr_if.data[PARK_WIDTH-1:0];
            default: begin
               // unknown index: ignored
            end
         endcase
      end
   end

   // backoff state, advanced once per accepted event word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_NOT_IDLE;
         spin_count_ff  <= '0;
         yield_count_ff <= '0;
         park_period_ff <= PARK_WIDTH'(sypb_pkg::PARK_MIN_RESET);
      end else if (req_take) begin
         phase_ff       <= phase_in;
         spin_count_ff  <= spin_count_in;
         yield_count_ff <= yield_count_in;
         park_period_ff <= park_period_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         rsp_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_action_ff <= rsp_action_in;
         rsp_park_ff   <= rsp_park_in;
      end
   end

   // checks
   `SYPB_ASSERT_NEXT(a_work_clears, req_take && req_if.had_work,
      phase_ff == PH_NOT_IDLE && spin_count_ff == '0 && yield_count_ff == '0)
   `SYPB_ASSERT_NEXT(a_spin_hint, req_take && !req_if.had_work && phase_ff == PH_SPIN,
      rsp_valid_ff && rsp_action_ff == sypb_pkg::ACT_SPIN)
   `SYPB_ASSERT_NOW(a_park_len_only_on_park,
      rsp_valid_ff && rsp_action_ff != sypb_pkg::ACT_PARK, rsp_park_ff == '0)
   `SYPB_ASSERT_NOW(a_park_entry_from_yield,
      phase_ff == PH_PARK && $past(phase_ff) != PH_PARK, $past(phase_ff) == PH_YIELD)

endmodule
